>>> design/ib32_pkg.sv
// Shared types, constants and functions for the interleaved base32 group decoder.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package ib32_pkg;

    localparam int unsigned GROUP_SYMBOLS = 8;
    localparam int unsigned GROUP_BYTES   = 5;
    localparam int unsigned VAL_W         = 5;
    localparam int unsigned WORD_W        = GROUP_SYMBOLS * VAL_W;
    localparam int unsigned COUNT_W       = 3;
    localparam int unsigned NBYTES_W      = 3;

    localparam logic [COUNT_W-1:0] LAST_SYMBOL = COUNT_W'(GROUP_SYMBOLS - 1);
    localparam logic [7:0]         LOWER_BASE  = 8'd97;
    localparam logic [VAL_W-1:0]   LOWER_OFS   = VAL_W'(97);
    localparam logic [VAL_W-1:0]   DIGIT_OFS   = VAL_W'(48 - 26);
    localparam logic [7:0]         PAD_MARK    = 8'h80;

    localparam int unsigned GQ_DEPTH = 2;
    localparam int unsigned GQ_PTR_W = 1;
    localparam int unsigned GQ_CNT_W = 2;

    typedef logic [VAL_W-1:0] t_val;

    typedef struct packed {
        logic [WORD_W-1:0]   word;
        logic [NBYTES_W-1:0] nbytes;
    } t_group;

    function automatic t_val map_symbol(input logic [7:0] sym);
        t_val v;
        if (sym >= LOWER_BASE) begin
            v = sym[VAL_W-1:0] - LOWER_OFS;
        end else begin
            v = sym[VAL_W-1:0] - DIGIT_OFS;
        end
        return v;
    endfunction

    function automatic logic [WORD_W-1:0] interleave(input t_val vals [GROUP_SYMBOLS]);
        logic [WORD_W-1:0] w;
        w = '0;
        for (int p = 0; p < GROUP_SYMBOLS / 2; p++) begin
            for (int k = 0; k < VAL_W; k++) begin
                w[WORD_W - 1 - 2 * VAL_W * p - 2 * (VAL_W - 1 - k)] = vals[2 * p][k];
                w[WORD_W - 2 - 2 * VAL_W * p - 2 * (VAL_W - 1 - k)] = vals[2 * p + 1][k];
            end
        end
        return w;
    endfunction

    function automatic logic [NBYTES_W-1:0] kept_bytes(input logic [WORD_W-1:0] w,
                                                       input logic cut);
        logic [NBYTES_W-1:0] n;
        n = NBYTES_W'(GROUP_BYTES);
        for (int j = GROUP_BYTES - 1; j >= 0; j--) begin
            if (cut && (w[WORD_W - 1 - 8 * j -: 8] == PAD_MARK)) begin
                n = NBYTES_W'(j);
            end
        end
        return n;
    endfunction

endpackage

>>> design/ib32_front.sv
// Front end: accepts symbols, maps them to 5-bit values and builds a group
// record on every eighth symbol. Depends on ib32_pkg.
`timescale 1ns / 1ps

module ib32_front (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    input  logic [7:0]             i_symbol,
    input  logic                   i_final_group,
    input  logic                   i_padded,
    output logic                   o_full,
    input  logic                   i_grp_full,
    output logic                   o_grp_push,
    output ib32_pkg::t_group       o_grp
);

    logic [ib32_pkg::COUNT_W-1:0] r_count;
    logic [ib32_pkg::COUNT_W-1:0] n_count;
    ib32_pkg::t_val               r_vals [ib32_pkg::GROUP_SYMBOLS-1];
    ib32_pkg::t_val               vals   [ib32_pkg::GROUP_SYMBOLS];
    ib32_pkg::t_val               cur_val;
    logic                         accept;
    logic                         group_done;

    assign o_full     = i_grp_full;
    assign accept     = i_push && !i_grp_full;
    assign group_done = accept && (r_count == ib32_pkg::LAST_SYMBOL);
    assign cur_val    = ib32_pkg::map_symbol(i_symbol);

    always_comb begin
        for (int i = 0; i < ib32_pkg::GROUP_SYMBOLS - 1; i++) begin
            vals[i] = r_vals[i];
        end
        vals[ib32_pkg::GROUP_SYMBOLS-1] = cur_val;
        o_grp.word   = ib32_pkg::interleave(vals);
        o_grp.nbytes = ib32_pkg::kept_bytes(o_grp.word, i_final_group && i_padded);
    end

    // drop groups that keep no byte
    assign o_grp_push = group_done && (o_grp.nbytes != '0);

    always_comb begin
        n_count = r_count;
        if (accept) begin
            n_count = group_done ? '0 : r_count + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && !group_done) begin
            r_vals[r_count] <= cur_val;
        end
    end

    a_push_on_eighth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_grp_push |-> (r_count == ib32_pkg::LAST_SYMBOL) && accept)
        else $error("group pushed before eighth symbol");

    a_count_wraps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        group_done |=> (r_count == '0))
        else $error("symbol count did not wrap");

endmodule

>>> design/ib32_gq.sv
// Short group queue between front and back ends.
// Depends on ib32_pkg.
`timescale 1ns / 1ps

module ib32_gq (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  ib32_pkg::t_group i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_empty,
    output ib32_pkg::t_group o_data
);

    ib32_pkg::t_group              r_mem [ib32_pkg::GQ_DEPTH];
    logic [ib32_pkg::GQ_PTR_W-1:0] r_wr_ptr;
    logic [ib32_pkg::GQ_PTR_W-1:0] r_rd_ptr;
    logic [ib32_pkg::GQ_CNT_W-1:0] r_cnt;
    logic [ib32_pkg::GQ_PTR_W-1:0] n_wr_ptr;
    logic [ib32_pkg::GQ_PTR_W-1:0] n_rd_ptr;
    logic [ib32_pkg::GQ_CNT_W-1:0] n_cnt;
    logic                          do_push;
    logic                          do_pop;

    localparam logic [ib32_pkg::GQ_PTR_W-1:0] PTR_MAX = ib32_pkg::GQ_PTR_W'(ib32_pkg::GQ_DEPTH - 1);
    localparam logic [ib32_pkg::GQ_CNT_W-1:0] CNT_MAX = ib32_pkg::GQ_CNT_W'(ib32_pkg::GQ_DEPTH);

    assign o_full  = (r_cnt == CNT_MAX);
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_cnt    = r_cnt;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_MAX) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_MAX) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_MAX)
        else $error("group queue count out of range");

endmodule

>>> design/ib32_back.sv
// Back end: walks the head group into an output register, one byte per cycle while that register is empty or popped.
// Depends on ib32_pkg.
`timescale 1ns / 1ps

module ib32_back (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_grp_empty,
    input  ib32_pkg::t_group       i_grp,
    output logic                   o_grp_pop,
    output logic                   o_empty,
    input  logic                   i_pop,
    output logic [7:0]             o_data_byte,
    output logic                   o_group_last
);

    logic [ib32_pkg::NBYTES_W-1:0] r_idx;
    logic [ib32_pkg::NBYTES_W-1:0] n_idx;
    logic                          r_out_valid;
    logic                          n_out_valid;
    logic [7:0]                    r_out_byte;
    logic                          r_out_last;
    logic                          load_slot;
    logic                          take;
    logic [7:0]                    sel_byte;
    logic                          sel_last;

    assign load_slot = !r_out_valid || i_pop;
    assign take      = load_slot && !i_grp_empty;
    assign sel_last  = ((r_idx + 1'b1) == i_grp.nbytes);
    assign o_grp_pop = take && sel_last;

    always_comb begin
        case (r_idx)
            3'd0:    sel_byte = i_grp.word[39:32];
            3'd1:    sel_byte = i_grp.word[31:24];
            3'd2:    sel_byte = i_grp.word[23:16];
            3'd3:    sel_byte = i_grp.word[15:8];
            3'd4:    sel_byte = i_grp.word[7:0];
            default: sel_byte = '0;
        endcase
    end

    always_comb begin
        n_idx       = r_idx;
        n_out_valid = r_out_valid;
        if (load_slot) begin
            n_out_valid = !i_grp_empty;
        end
        if (take) begin
            n_idx = sel_last ? '0 : r_idx + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out_byte <= sel_byte;
            r_out_last <= sel_last;
        end
    end

    assign o_empty      = !r_out_valid;
    assign o_data_byte  = r_out_byte;
    assign o_group_last = r_out_last;

    a_idx_in_group: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_grp_empty |-> (i_grp.nbytes != '0) && (r_idx < i_grp.nbytes))
        else $error("byte index outside head group");

    a_idx_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_grp_pop |=> (r_idx == '0))
        else $error("byte index not reset after group");

    a_idle_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_grp_empty |-> (r_idx == '0))
        else $error("byte index moved with no group");

endmodule

>>> design/interleaved_base32_group_decoder.sv
// Top level of the interleaved base32 group decoder.
// Instantiates ib32_front, ib32_gq and ib32_back; depends on ib32_pkg.
//
//  channel  | handshake          | payload
//  ---------+--------------------+--------------------------------------
//  input    | i_push / o_full    | i_symbol, i_final_group, i_padded
//  result   | o_empty / i_pop    | o_data_byte, o_group_last
//
// One symbol is taken per cycle while o_full is low; every eighth symbol turns into up to five
// bytes that leave one per cycle while i_pop is held, through a registered output stage.
// A completed group passes through the group queue and then the output register before it appears on the outputs.
// A two-entry group queue separates symbol intake from byte output; o_full
// rises only when both entries hold groups still being drained.
// Reset (synchronous, active low) clears the symbol count, queue, byte index and output valid flag.
`timescale 1ns / 1ps

module interleaved_base32_group_decoder (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    output logic       o_full,
    input  logic [7:0] i_symbol,
    input  logic       i_final_group,
    input  logic       i_padded,
    output logic       o_empty,
    input  logic       i_pop,
    output logic [7:0] o_data_byte,
    output logic       o_group_last
);

    ib32_pkg::t_group grp_in;
    ib32_pkg::t_group grp_head;
    logic             grp_push;
    logic             grp_full;
    logic             grp_pop;
    logic             grp_empty;

    ib32_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (i_push),
        .i_symbol      (i_symbol),
        .i_final_group (i_final_group),
        .i_padded      (i_padded),
        .o_full        (o_full),
        .i_grp_full    (grp_full),
        .o_grp_push    (grp_push),
        .o_grp         (grp_in)
    );

    ib32_gq u_gq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (grp_push),
        .i_data  (grp_in),
        .o_full  (grp_full),
        .i_pop   (grp_pop),
        .o_empty (grp_empty),
        .o_data  (grp_head)
    );

    ib32_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_grp_empty  (grp_empty),
        .i_grp        (grp_head),
        .o_grp_pop    (grp_pop),
        .o_empty      (o_empty),
        .i_pop        (i_pop),
        .o_data_byte  (o_data_byte),
        .o_group_last (o_group_last)
    );

endmodule

>>> tb/interleaved_base32_group_decoder_test.sv
// Self-checking testbench for interleaved_base32_group_decoder: random and directed symbol
// groups are checked byte by byte against a built-in group decoding predictor.
// Depends on ib32_pkg and the design files of the block.
`timescale 1ns / 1ps

module interleaved_base32_group_decoder_test;

    typedef struct packed {
        logic [7:0] symbol;
        logic       final_group;
        logic       padded;
    } t_symbol_item;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_out_byte;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_push = 1'b0;
    logic [7:0] i_symbol = '0;
    logic       i_final_group = 1'b0;
    logic       i_padded = 1'b0;
    logic       i_pop = 1'b0;
    logic       o_full;
    logic       o_empty;
    logic [7:0] o_data_byte;
    logic       o_group_last;

    t_symbol_item pending_symbols[$];
    t_out_byte    expected_bytes[$];
    logic [4:0]   group_vals[ib32_pkg::GROUP_SYMBOLS];
    int unsigned  group_fill = 0;
    int unsigned  send_idle_pct = 30;
    int unsigned  recv_idle_pct = 57;
    int unsigned  error_count = 0;
    logic         push_taken = 1'b0;

    interleaved_base32_group_decoder dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (i_push),
        .o_full        (o_full),
        .i_symbol      (i_symbol),
        .i_final_group (i_final_group),
        .i_padded      (i_padded),
        .o_empty       (o_empty),
        .i_pop         (i_pop),
        .o_data_byte   (o_data_byte),
        .o_group_last  (o_group_last)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    function automatic logic [4:0] symbol_value(input logic [7:0] s);
        return (s >= 8'd97) ? 5'(s - 8'd97) : 5'(s - 8'd22);
    endfunction

    function automatic logic [7:0] encode_value(input logic [4:0] v);
        logic [7:0] s;
        if ($urandom_range(0, 1) == 0) begin
            return (v < 5'd26) ? 8'(8'd97 + v) : 8'(8'd22 + v);
        end
        do begin
            s = 8'($urandom_range(0, 255));
        end while (symbol_value(s) != v);
        return s;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        error_count++;
        $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
    endtask

    task automatic decode_symbol(input logic [7:0] s, input logic fin, input logic pad);
        logic [39:0] word;
        logic [7:0]  b;
        t_out_byte   group_out[$];
        group_vals[group_fill] = symbol_value(s);
        if (group_fill != ib32_pkg::GROUP_SYMBOLS - 1) begin
            group_fill++;
            return;
        end
        group_fill = 0;
        word = '0;
        for (int p = 0; p < 4; p++) begin
            for (int k = 4; k >= 0; k--) begin
                word = {word[38:0], group_vals[2 * p][k]};
                word = {word[38:0], group_vals[2 * p + 1][k]};
            end
        end
        for (int j = 0; j < ib32_pkg::GROUP_BYTES; j++) begin
            b = word[39 - 8 * j -: 8];
            if (fin && pad && b == ib32_pkg::PAD_MARK) begin
                break;
            end
            group_out.push_back('{data: b, last: 1'b0});
        end
        if (group_out.size() != 0) begin
            group_out[group_out.size() - 1].last = 1'b1;
        end
        foreach (group_out[j]) begin
            expected_bytes.push_back(group_out[j]);
        end
    endtask

    task automatic queue_word_group(input logic [39:0] word, input logic fin,
                                    input logic pad);
        logic [4:0] vals[ib32_pkg::GROUP_SYMBOLS];
        for (int p = 0; p < 4; p++) begin
            for (int k = 0; k < 5; k++) begin
                vals[2 * p][4 - k]     = word[39 - 10 * p - 2 * k];
                vals[2 * p + 1][4 - k] = word[38 - 10 * p - 2 * k];
            end
        end
        for (int i = 0; i < ib32_pkg::GROUP_SYMBOLS; i++) begin
            pending_symbols.push_back('{
                symbol: encode_value(vals[i]),
                final_group: (i == ib32_pkg::GROUP_SYMBOLS - 1) ? fin
                                                                : 1'($urandom_range(0, 1)),
                padded: (i == ib32_pkg::GROUP_SYMBOLS - 1) ? pad : 1'($urandom_range(0, 1))
            });
        end
    endtask

    task automatic queue_random_group();
        logic [39:0] word;
        word = {8'($urandom), 32'($urandom)};
        if ($urandom_range(0, 9) == 0) begin
            for (int i = 0; i < ib32_pkg::GROUP_SYMBOLS; i++) begin
                pending_symbols.push_back('{symbol: 8'($urandom), final_group: 1'($urandom),
                                           padded: 1'($urandom)});
            end
            return;
        end
        if ($urandom_range(0, 99) < 50) begin
            word[39 - 8 * $urandom_range(0, 4) -: 8] = ib32_pkg::PAD_MARK;
            if ($urandom_range(0, 3) == 0) begin
                word[39 - 8 * $urandom_range(0, 4) -: 8] = ib32_pkg::PAD_MARK;
            end
        end
        queue_word_group(word, $urandom_range(0, 99) < 65, $urandom_range(0, 99) < 65);
    endtask

    // driver
    always @(posedge i_clk) begin
        push_taken <= i_rst_n && i_push && !o_full;
        if (i_rst_n && i_push && !o_full) begin
            decode_symbol(i_symbol, i_final_group, i_padded);
        end
    end

    always @(negedge i_clk) begin
        t_symbol_item item;
        if (!i_rst_n) begin
            i_push <= 1'b0;
        end else if (!i_push || push_taken) begin
            if (pending_symbols.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                item = pending_symbols.pop_front();
                i_push        <= 1'b1;
                i_symbol      <= item.symbol;
                i_final_group <= item.final_group;
                i_padded      <= item.padded;
            end else begin
                i_push        <= 1'b0;
                i_symbol      <= 8'($urandom);
                i_final_group <= 1'($urandom);
                i_padded      <= 1'($urandom);
            end
        end
    end

    // monitor
    always @(negedge i_clk) begin
        i_pop <= i_rst_n && ($urandom_range(0, 99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin
        t_out_byte want;
        if (i_rst_n && i_pop && !o_empty) begin
            if (expected_bytes.size() == 0) begin
                report_mismatch("unexpected transfer, data_byte", o_data_byte, 0);
            end else begin
                want = expected_bytes.pop_front();
                if (o_data_byte !== want.data) begin
                    report_mismatch("data_byte", o_data_byte, want.data);
                end
                if (o_group_last !== want.last) begin
                    report_mismatch("group_last", o_group_last, want.last);
                end
            end
        end
    end

    initial begin
        #400000;
        $display("FAIL interleaved_base32_group_decoder");
        $finish;
    end

    initial begin
        logic [7:0] extremes[ib32_pkg::GROUP_SYMBOLS];
        extremes = '{8'd0, 8'd255, 8'd96, 8'd97, 8'd122, 8'd48, 8'd53, 8'd127};
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < ib32_pkg::GROUP_SYMBOLS; i++) begin
            pending_symbols.push_back('{symbol: extremes[i],
                                       final_group: (i != ib32_pkg::GROUP_SYMBOLS - 1),
                                       padded: (i != ib32_pkg::GROUP_SYMBOLS - 1)});
        end
        queue_word_group(40'h80_1234_5678, 1'b1, 1'b1);
        queue_word_group(40'hff_00_2a_80_7f, 1'b1, 1'b1);

        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 30 : (phase == 1) ? 57 : 0;
            recv_idle_pct = (phase == 0) ? 57 : (phase == 1) ? 30 : 0;
            repeat (20) queue_random_group();
            while (pending_symbols.size() != 0) @(negedge i_clk);
        end

        while (i_push) @(negedge i_clk);
        while (expected_bytes.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
        if (error_count == 0) begin
            $display("PASS interleaved_base32_group_decoder");
        end else begin
            $display("FAIL interleaved_base32_group_decoder");
        end
        $finish;
    end

endmodule
